>>> sv/stit_pkg.sv
package stit_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int TIME_BITS_DEF = 24;

    localparam int KIND_W    = 2;
    localparam int TIME_MS_W = 24;
    localparam int LINE_W    = 8;
    localparam int COUNT_W   = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic set_drop;
        logic rd_mid;
        logic cmp_step;
        logic rd_shift;
        logic wr_shift;
        logic put;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  search_go;
        logic  shift_go;
        logic  out_free;
    } t_sts;

endpackage

>>> sv/stit_if.sv
interface stit_in_if import stit_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TIME_MS_W-1:0] time_ms;

    modport source (output valid, output kind, output time_ms, input ready);
    modport sink   (input valid, input kind, input time_ms, output ready);
endinterface

interface stit_out_if import stit_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LINE_W-1:0]  line_index;
    logic [COUNT_W-1:0] entry_count;
    logic               dropped;

    modport source (output valid, output line_index, output entry_count, output dropped,
                    input ready);
    modport sink   (input valid, input line_index, input entry_count, input dropped,
                    output ready);
endinterface

>>> sv/stit_ctrl.sv
module stit_ctrl import stit_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    KIND_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DONE;
                    end
                    KIND_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.set_drop = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    KIND_QUERY: begin
                        n_state = S_SRCH_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SRCH_RD: begin
                if (i_sts.search_go) begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = S_SRCH_CMP;
                end else if (i_sts.kind == KIND_INSERT) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.cmp_step = 1'b1;
                n_state        = S_SRCH_RD;
            end
            S_SH_RD: begin
                if (i_sts.shift_go) begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SH_WR;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SH_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/stit_dp.sv
module stit_dp import stit_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [TIME_MS_W-1:0] i_time_ms,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [LINE_W-1:0]    o_line_index,
    output logic [COUNT_W-1:0]   o_entry_count,
    output logic                 o_dropped
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TIME_BITS-1:0] r_mem [DEPTH];
    logic [TIME_BITS-1:0] r_rd_data;

    t_kind                r_kind;
    logic [TIME_BITS-1:0] r_time;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        r_j;
    logic                 r_drop;

    logic                 r_out_valid;
    logic [LINE_W-1:0]    r_line;
    logic [COUNT_W-1:0]   r_cnt_out;
    logic                 r_drop_out;

    logic [CW:0]          sum_lo_hi;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        j_dec;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [TIME_BITS-1:0] wr_data;
    logic                 wr_en;
    logic                 rd_en;
    logic [CW-1:0]        lo_dec;
    logic [LINE_W-1:0]    n_line;

    assign sum_lo_hi = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = sum_lo_hi[CW:1];
    assign j_dec     = r_j - CW'(1);
    assign lo_dec    = r_lo - CW'(1);

    assign rd_en   = i_cmd.rd_mid | i_cmd.rd_shift;
    assign rd_addr = i_cmd.rd_shift ? j_dec[AW-1:0] : mid[AW-1:0];
    assign wr_en   = i_cmd.wr_shift | i_cmd.put;
    assign wr_addr = i_cmd.wr_shift ? r_j[AW-1:0] : r_lo[AW-1:0];
    assign wr_data = i_cmd.wr_shift ? r_rd_data : r_time;

    // table store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_time <= TIME_BITS'(i_time_ms);
            r_lo   <= '0;
            r_hi   <= r_count;
            r_j    <= r_count;
            r_drop <= 1'b0;
        end else begin
            if (i_cmd.set_drop) begin
                r_drop <= 1'b1;
            end
            // upper-bound search: lo ends at the number of entries <= time
            if (i_cmd.cmp_step) begin
                if (r_rd_data <= r_time) begin
                    r_lo <= mid + CW'(1);
                end else begin
                    r_hi <= mid;
                end
            end
            if (i_cmd.wr_shift) begin
                r_j <= j_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.put) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_comb begin
        n_line = '0;
        if (r_kind == KIND_QUERY && r_lo != '0) begin
            n_line = LINE_W'(lo_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_line     <= n_line;
            r_cnt_out  <= COUNT_W'(r_count);
            r_drop_out <= r_drop;
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.search_go = (r_lo < r_hi);
    assign o_sts.shift_go  = (r_j > r_lo);
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_line_index  = r_line;
    assign o_entry_count = r_cnt_out;
    assign o_dropped     = r_drop_out;

endmodule

>>> sv/sorted_time_index_table.sv
// channel | dir | handshake          | payload
// i_in    | in  | valid/ready        | kind[1:0], time_ms[23:0]
// o_out   | out | valid/ready        | line_index[7:0], entry_count[8:0], dropped
//
// One item at a time. Clear, full insert and unused kind: dispatch, then the result load.
// Query: dispatch, then S binary search steps, S at most ceil(log2(count+1)); each step
// is one read of the table memory plus one compare.
// Insert: as query, then M entries moved up one slot (one read and one write each), then the put.
// A waiting result sits in the output register; the next item is taken once it is loaded.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module sorted_time_index_table import stit_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stit_in_if.sink       i_in,
    stit_out_if.source    o_out
);

    t_cmd cmd;
    t_sts sts;

    stit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stit_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (i_in.kind),
        .i_time_ms     (i_in.time_ms),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_line_index  (o_out.line_index),
        .o_entry_count (o_out.entry_count),
        .o_dropped     (o_out.dropped)
    );

endmodule
